// ===== src/decaying_partial_additive_oscillator_defines.svh =====
// Assertion macros for the additive oscillator checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DECAYING_PARTIAL_ADDITIVE_OSCILLATOR_DEFINES_SVH
`define DECAYING_PARTIAL_ADDITIVE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DPAO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpao assertion failed");

// Next-cycle implication, off during reset.
`define DPAO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpao assertion failed");

// Next-cycle implication that also holds through reset.
`define DPAO_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpao reset assertion failed");

`endif

// ===== src/dpao_pkg.sv =====
// Shared constants, types, sine table and ratio table for the additive oscillator.
// No dependencies.
package dpao_pkg;

  localparam int NUM_PARTIALS    = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int IDX_W         = $clog2(NUM_PARTIALS);
  localparam int PIDX_W        = (IDX_W > 3) ? IDX_W : 3;
  localparam int QUARTER_STEPS = 1 << (SINE_TABLE_BITS - 2);
  localparam int ROM_IDX_W     = SINE_TABLE_BITS - 1;
  localparam int SINE_W        = 15;
  localparam int WEIGHT_W      = 16;
  localparam int FUND_W        = 31;
  localparam int SPACE_W       = 16;
  localparam int DEV_W         = 16;
  localparam int MUL_A_W       = 31;
  localparam int MUL_B_W       = 16;
  localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int TOT_W         = WEIGHT_W + IDX_W;
  localparam int NUM_W         = 32 + IDX_W;
  localparam int QUO_W         = 16;
  localparam int DVS_W         = TOT_W + QUO_W - 1;
  localparam int DIV_CNT_W     = $clog2(QUO_W);
  localparam int RATIO_FRAC    = 28;
  localparam int FULL_W        = 65;
  localparam int STEP_LSB      = RATIO_FRAC + 32 - PHASE_BITS;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRIG = 2'd1,
    REQ_TICK = 2'd2
  } dpao_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FUND  = 2'd0,
    CFG_SPACE = 2'd1,
    CFG_MODE  = 2'd2
  } dpao_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_MUL,
    S_DEC_WB,
    S_CHECK,
    S_SIN_MUL,
    S_DEV_MUL,
    S_LO_MUL,
    S_HI_MUL,
    S_STEP,
    S_PHASE,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } dpao_state_t;

  // sequencer -> datapath
  typedef struct packed {
    dpao_state_t          st;
    logic [IDX_W-1:0]     idx;
  } dpao_ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic tick_go;
    logic total_zero;
    logic div_done;
    logic out_free;
  } dpao_sts_t;

  // membrane deviations from 1, Q4.12
  localparam logic [DEV_W-1:0] MEMBRANE_DEV [8] = '{
    16'd0, 16'd2430, 16'd4651, 16'd5306, 16'd6769, 16'd7853, 16'd8828, 16'd10240
  };

  function automatic logic [DEV_W-1:0] dev_of(input logic [IDX_W-1:0] i,
                                              input logic membrane);
    logic [PIDX_W-1:0] ie;
    logic [DEV_W-1:0]  d;
    ie = PIDX_W'(i);
    if (membrane) begin
      if (32'(ie) >= 8) d = MEMBRANE_DEV[7];
      else              d = MEMBRANE_DEV[ie[2:0]];
    end else begin
      d = DEV_W'(ie) << 12;
    end
    return d;
  endfunction

  typedef logic [QUARTER_STEPS:0][SINE_W-1:0] rom_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Quarter-wave table, Taylor series in Q30, evaluated at elaboration only.
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      r[k] = SINE_W'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    return r;
  endfunction

  localparam rom_t QUARTER_ROM = build_rom();

endpackage

// ===== src/dpao_mul.sv =====
// Shared unsigned multiplier with registered product.
// Depends on dpao_pkg.
module dpao_mul import dpao_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== src/dpao_div.sv =====
// Restoring divider, one quotient bit per cycle, for sample normalization.
// Depends on dpao_pkg. Caller guarantees dividend < divisor * 2^QUO_W.
module dpao_div import dpao_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [TOT_W-1:0]   divisor,
  output logic               done,
  output logic [QUO_W-1:0]   quot
);

  logic [NUM_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 fits;

  assign fits = NUM_W'(dvs_r) <= rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= DVS_W'(divisor) << (QUO_W - 1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r  <= rem_r - NUM_W'(dvs_r);
        quot_r <= {quot_r[QUO_W-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[QUO_W-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== src/dpao_ctrl.sv =====
// Sequencer: walks the partials through decay, sine, step and phase phases.
// Depends on dpao_pkg.
module dpao_ctrl import dpao_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dpao_sts_t  sts,
  output dpao_ctl_t  ctl
);

  dpao_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last;

  assign last = idx_r == IDX_W'(NUM_PARTIALS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (sts.tick_go) state_nxt = S_DEC_MUL;
      S_DEC_MUL:   state_nxt = S_DEC_WB;
      S_DEC_WB:    state_nxt = last ? S_CHECK : S_DEC_MUL;
      S_CHECK:     state_nxt = sts.total_zero ? S_EMIT : S_SIN_MUL;
      S_SIN_MUL:   state_nxt = S_DEV_MUL;
      S_DEV_MUL:   state_nxt = S_LO_MUL;
      S_LO_MUL:    state_nxt = S_HI_MUL;
      S_HI_MUL:    state_nxt = S_STEP;
      S_STEP:      state_nxt = S_PHASE;
      S_PHASE:     state_nxt = last ? S_DIV_START : S_SIN_MUL;
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  if (sts.div_done) state_nxt = S_EMIT;
      S_EMIT:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // partial counter
  always_comb begin
    idx_nxt = idx_r;
    unique case (state_r)
      S_IDLE, S_CHECK: idx_nxt = '0;
      S_DEC_WB:        idx_nxt = last ? '0 : idx_r + 1'b1;
      S_PHASE:         idx_nxt = last ? '0 : idx_r + 1'b1;
      default:         idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    ctl.st  = state_r;
    ctl.idx = idx_r;
  end

endmodule

// ===== src/decaying_partial_additive_oscillator.sv =====
// Top level of the eight-partial decaying additive sine oscillator.
// Depends on dpao_pkg, dpao_mul, dpao_div and dpao_ctrl.
//
// Load items (req_type 0) write one partial's Q0.16 weight and decay factor and
// trigger items (req_type 1) zero every phase; both finish at the accepting edge,
// produce no result, and in_ready stays high. A tick item (req_type 2) runs a
// sequencer around a single 31x16 multiplier: first every weight is decayed
// (a multiply and a write-back per partial), then each partial runs through
// its sine product, ratio product, two step products and phase update, and
// finally a restoring divider normalizes the sum by the total weight. A tick
// holds the input side until it is done; when the decayed total is zero it
// ends after the decay walk with a silent result of zero. A result sits in
// an output register, so loads and triggers are taken while it waits, and a
// tick only stalls at its last step if the previous result has still not
// been taken. Request code 3 is dropped.
// Configuration writes take effect at once and must only be made while idle.
module decaying_partial_additive_oscillator import dpao_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [2:0]            in_partial_index,
  input  logic [15:0]           in_initial_weight,
  input  logic [15:0]           in_decay_factor,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample,
  output logic                  out_silent,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [FUND_W-1:0]  fund_r;
  logic [SPACE_W-1:0] space_r;
  logic               mode_r;

  // per-partial state
  logic [WEIGHT_W-1:0]   weight_r [NUM_PARTIALS];
  logic [WEIGHT_W-1:0]   decay_r  [NUM_PARTIALS];
  logic [PHASE_BITS-1:0] phase_r  [NUM_PARTIALS];

  // tick working registers
  logic [TOT_W-1:0]      total_r;
  logic [NUM_W-1:0]      num_r;     // two's complement weighted sine sum
  logic                  neg_r;     // sign of the sine in flight
  logic [15:0]           phi_r;     // upper half of dev*space
  logic [FULL_W-1:0]     lo_r;      // fund<<28 plus low step product
  logic [PHASE_BITS-1:0] step_r;

  logic                  out_valid_r;
  logic signed [15:0]    out_sample_r;
  logic                  out_silent_r;

  dpao_ctl_t ctl;
  dpao_sts_t sts;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic               div_done;
  logic [QUO_W-1:0]   quot;
  logic [NUM_W-1:0]   mag;
  logic [NUM_W-1:0]   dividend;

  logic                       accept;
  logic [PIDX_W-1:0]          ld_idx;
  logic [PHASE_BITS-1:0]      cur_phase;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [ROM_IDX_W-1:0]       rom_k;
  logic [SINE_W-1:0]          sin_mag;
  logic                       sin_neg;
  logic [DEV_W-1:0]           dev;
  logic [FULL_W-1:0]          full;
  logic [16:0]                neg_q;
  logic signed [15:0]         sample_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = ctl.st == S_IDLE;
  assign ld_idx   = PIDX_W'(in_partial_index);

  always_comb begin
    sts.tick_go    = accept && (in_req_type == REQ_TICK);
    sts.total_zero = total_r == '0;
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

  dpao_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // quarter-wave lookup: odd quadrants mirror, upper half negates
  assign cur_phase = phase_r[ctl.idx];
  assign sidx      = cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign sin_neg   = sidx[SINE_TABLE_BITS-1];
  assign rom_k     = sidx[SINE_TABLE_BITS-2]
                   ? ROM_IDX_W'(QUARTER_STEPS) - {1'b0, sidx[SINE_TABLE_BITS-3:0]}
                   : {1'b0, sidx[SINE_TABLE_BITS-3:0]};
  assign sin_mag   = QUARTER_ROM[rom_k];
  assign dev       = dev_of(ctl.idx, mode_r);

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctl.st)
      S_DEC_MUL: begin
        mul_a = MUL_A_W'(weight_r[ctl.idx]);
        mul_b = decay_r[ctl.idx];
      end
      S_SIN_MUL: begin
        mul_a = MUL_A_W'(weight_r[ctl.idx]);
        mul_b = MUL_B_W'(sin_mag);
      end
      S_DEV_MUL: begin
        mul_a = MUL_A_W'(dev);
        mul_b = space_r;
      end
      S_LO_MUL: begin
        mul_a = fund_r;
        mul_b = prod[15:0];
      end
      S_HI_MUL: begin
        mul_a = fund_r;
        mul_b = phi_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dpao_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // round to nearest: (|N| + T/2) / T
  assign mag      = num_r[NUM_W-1] ? NUM_W'(0) - num_r : num_r;
  assign dividend = mag + NUM_W'(total_r >> 1);

  dpao_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.st == S_DIV_START),
    .dividend (dividend),
    .divisor  (total_r),
    .done     (div_done),
    .quot     (quot)
  );

  // step = (fund * (2^28 + 2*dev*space)) >> STEP_LSB, split over two products
  assign full = (FULL_W'(prod) << 17) + lo_r;

  assign neg_q = 17'd0 - {1'b0, quot};
  always_comb begin
    if (num_r[NUM_W-1]) begin
      if (quot > 16'd32768) sample_val = -16'sd32768;
      else                  sample_val = $signed(neg_q[15:0]);
    end else begin
      if (quot > 16'd32767) sample_val = 16'sd32767;
      else                  sample_val = $signed(quot);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fund_r  <= '0;
      space_r <= SPACE_W'(32768);
      mode_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FUND:  fund_r  <= cfg_wdata;
        CFG_SPACE: space_r <= cfg_wdata[SPACE_W-1:0];
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // partial stores, accumulators and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PARTIALS; i++) begin
        weight_r[i] <= '0;
        decay_r[i]  <= '0;
        phase_r[i]  <= '0;
      end
      total_r     <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may land in the same cycle the old one is taken
      if (ctl.st == S_EMIT && sts.out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)    out_valid_r <= 1'b0;
      unique case (ctl.st)
        S_IDLE: begin
          if (accept) begin
            unique case (in_req_type)
              REQ_LOAD: begin
                if (32'(ld_idx) < NUM_PARTIALS) begin
                  weight_r[ld_idx[IDX_W-1:0]] <= in_initial_weight;
                  decay_r[ld_idx[IDX_W-1:0]]  <= in_decay_factor;
                end
              end
              REQ_TRIG: begin
                for (int i = 0; i < NUM_PARTIALS; i++) phase_r[i] <= '0;
              end
              REQ_TICK: total_r <= '0;
              default:  ;
            endcase
          end
        end
        S_DEC_WB: begin
          weight_r[ctl.idx] <= prod[31:16];
          total_r           <= total_r + TOT_W'(prod[31:16]);
        end
        S_CHECK: num_r <= '0;
        S_DEV_MUL: begin
          // weight * |sine| fits in 31 bits
          if (neg_r) num_r <= num_r - NUM_W'(prod[30:0]);
          else       num_r <= num_r + NUM_W'(prod[30:0]);
        end
        S_PHASE: phase_r[ctl.idx] <= phase_r[ctl.idx] + step_r;
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    unique case (ctl.st)
      S_SIN_MUL: neg_r  <= sin_neg;
      S_LO_MUL:  phi_r  <= prod[31:16];
      S_HI_MUL:  lo_r   <= (FULL_W'(prod) << 1) + (FULL_W'(fund_r) << RATIO_FRAC);
      S_STEP:    step_r <= full[STEP_LSB +: PHASE_BITS];
      S_EMIT: begin
        if (sts.out_free) begin
          out_silent_r <= sts.total_zero;
          out_sample_r <= sts.total_zero ? 16'sd0 : sample_val;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_silent = out_silent_r;

endmodule

// ===== src/dpao_chk.sv =====
// Port-level checker for the additive oscillator, bound to the top level.
// Depends on dpao_pkg and decaying_partial_additive_oscillator_defines.svh.
`include "decaying_partial_additive_oscillator_defines.svh"

module dpao_chk import dpao_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [15:0]    out_sample,
  input logic                  out_silent
);

  // a silent result carries a zero sample
  `DPAO_ASSERT_NOW(a_silent_zero, out_valid && out_silent, out_sample == 16'sd0)

  // a tick occupies the sequencer, so input side closes right after it
  `DPAO_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_req_type == REQ_TICK, !in_ready)

  // loads and triggers complete in the accepting cycle
  `DPAO_ASSERT_NEXT(a_load_quick, in_valid && in_ready && in_req_type != REQ_TICK, in_ready)

  // a stalled result holds
  `DPAO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_silent))

  // nothing is offered right after reset
  `DPAO_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind decaying_partial_additive_oscillator dpao_chk u_dpao_chk (.*);

// ===== tb/decaying_partial_additive_oscillator_test.sv =====
// Self-checking bench for the eight-partial decaying additive sine oscillator.
// Needs dpao_pkg (request and register codes) and decaying_partial_additive_oscillator.
// A local fixed-point voice model predicts each tick's sample; a monitor compares them.
module decaying_partial_additive_oscillator_test;
  import dpao_pkg::*;

  localparam int          VOICES        = 8;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 120;   // longer than a full tick
  localparam int          HOLD_CYCLES   = 600;   // long sink stall, spans several ticks
  localparam int          PHASE_ITEMS   = 260;
  localparam int          MAX_PRINTS    = 100;
  localparam logic [1:0]  REQ_NONE      = 2'd3;  // unused request code, dropped by the block

  // Membrane mode ratio deviations from 1, Q4.12 (Bessel zero ratios).
  localparam longint unsigned BESSEL_DEV [VOICES] = '{
    0, 2430, 4651, 5306, 6769, 7853, 8828, 10240
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               silent;
  } voice_out_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type       = '0;
  logic [2:0]            in_partial_index  = '0;
  logic [15:0]           in_initial_weight = '0;
  logic [15:0]           in_decay_factor   = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic signed [15:0]    out_sample;
  logic                  out_silent;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  // Voice model: registers, per-partial stores and the quarter-wave sine table.
  logic [30:0] m_fund;
  logic [15:0] m_space;
  logic        m_membrane;
  logic [15:0] m_weight [VOICES];
  logic [15:0] m_decay  [VOICES];
  logic [31:0] m_phase  [VOICES];
  int          sine_quarter [0:256];

  voice_out_t  sample_q [$];       // predicted samples, oldest first
  int          err_count    = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 1'b0; // no random idling on either side
  bit          hold_request = 1'b0; // asks the sink for one long stall

  decaying_partial_additive_oscillator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_partial_index  (in_partial_index),
    .in_initial_weight (in_initial_weight),
    .in_decay_factor   (in_decay_factor),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample),
    .out_silent        (out_silent),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop if the block hangs or a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Voice model
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    m_fund     = '0;
    m_space    = 16'd32768;
    m_membrane = 1'b1;
    foreach (m_weight[i]) begin
      m_weight[i] = '0;
      m_decay[i]  = '0;
      m_phase[i]  = '0;
    end
  endtask

  // Quarter sine in Q30 via nested Taylor terms, then scaled to 15 bits with
  // round half up. Every product and division truncates.
  function automatic void fill_sine_quarter();
    longint unsigned x, x2, t, s;
    for (int k = 0; k <= 256; k++) begin
      x  = (64'(k) * 64'd1686629713) >> 8;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      sine_quarter[k] = int'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    end
  endfunction

  // Top 10 phase bits index the full wave; odd quadrants mirror, upper half negates.
  function automatic int sine_of(logic [31:0] ph);
    logic [1:0] quad;
    logic [8:0] k;
    quad = ph[31:30];
    k    = {1'b0, ph[29:22]};
    if (quad[0])
      k = 9'd256 - k;
    return quad[1] ? -sine_quarter[k] : sine_quarter[k];
  endfunction

  // Phase step of partial i: fundamental times the stretched ratio (Q4.28).
  function automatic logic [31:0] phase_step(int i);
    longint unsigned dev, ratio, prod;
    dev   = m_membrane ? BESSEL_DEV[i] : (64'(i) << 12);
    ratio = (64'd1 << 28) + dev * m_space * 64'd2;
    prod  = m_fund * ratio;
    return 32'(prod >> 28);
  endfunction

  // Applies one accepted item to the model; a tick queues its predicted sample.
  function automatic void predict_item(logic [1:0] req, logic [2:0] idx,
                                       logic [15:0] w, logic [15:0] d);
    longint unsigned total, mag, q;
    longint          num;
    int              s;
    voice_out_t      r;
    case (req)
      REQ_LOAD: begin
        m_weight[idx] = w;
        m_decay[idx]  = d;
      end
      REQ_TRIG: begin
        foreach (m_phase[i]) m_phase[i] = '0;
      end
      REQ_TICK: begin
        total = 0;
        num   = 0;
        foreach (m_weight[i]) begin
          m_weight[i] = 16'((32'(m_weight[i]) * m_decay[i]) >> 16);
          total += m_weight[i];
        end
        if (total == 0) begin
          // all weights gone: silence, phases hold
          r.sample = '0;
          r.silent = 1'b1;
        end else begin
          for (int i = 0; i < VOICES; i++) begin
            num += longint'(m_weight[i]) * sine_of(m_phase[i]);
            m_phase[i] = m_phase[i] + phase_step(i);
          end
          mag = (num < 0) ? longint'(-num) : longint'(num);
          q   = (mag + total / 2) / total;
          if (num < 0)
            s = (q > 32768) ? -32768 : -int'(q);
          else
            s = (q > 32767) ? 32767 : int'(q);
          r.sample = 16'(s);
          r.silent = 1'b0;
        end
        sample_q.push_back(r);
      end
      default: ;  // unknown code: nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // Values are read at the edge before any update, so handshakes are seen as taken.
  always @(posedge clk) begin : sample_monitor
    voice_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        report_mismatch("unexpected sample", int'(out_sample), 0);
      end else begin
        want = sample_q.pop_front();
        if (out_sample !== want.sample)
          report_mismatch("sample", int'(out_sample), int'(want.sample));
        if (out_silent !== want.silent)
          report_mismatch("silent", int'(out_silent), int'(want.silent));
      end
    end
  end

  // Sink: random short stalls, quiet stretches, and one long hold on request.
  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 3) begin
        idle_left = $urandom_range(3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one item, maybe after a short gap, and holds it until taken.
  task automatic send_item(logic [1:0] req, logic [2:0] idx, logic [15:0] w,
                           logic [15:0] d);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_partial_index  <= idx;
    in_initial_weight <= w;
    in_decay_factor   <= d;
    do @(posedge clk); while (!in_ready);
    predict_item(req, idx, w, d);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_config(logic [30:0] fund, logic [15:0] space, logic mode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FUND;
    cfg_wdata <= fund;
    @(posedge clk);
    m_fund     = fund;
    cfg_index <= CFG_SPACE;
    cfg_wdata <= CFG_DATA_W'(space);
    @(posedge clk);
    m_space    = space;
    cfg_index <= CFG_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    m_membrane = mode;
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, wait for every predicted sample, then let the sequencer settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_weight();
    int r;
    r = $urandom_range(9);
    return (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
  endfunction

  // Mostly slow decays so voices stay audible over several ticks.
  function automatic logic [15:0] rand_decay();
    int r;
    r = $urandom_range(9);
    return (r == 0) ? 16'hFFFF : (r == 1) ? 16'($urandom) : 16'($urandom_range(65535, 50000));
  endfunction

  function automatic logic [30:0] rand_fund();
    return $urandom_range(1) ? 31'($urandom_range(32'h0400_0000)) : 31'($urandom);
  endfunction

  task automatic test_directed();
    // reset state: nothing loaded, so the first tick is silent
    send_item(REQ_TICK, 3'd0, 16'h0000, 16'h0000);
    send_item(REQ_LOAD, 3'd0, 16'hFFFF, 16'hFFFF);
    send_item(REQ_LOAD, 3'd7, 16'hFFFF, 16'h0000);   // dies on the first tick
    send_item(REQ_NONE, 3'd5, 16'hA5A5, 16'h5A5A);   // dropped
    send_item(REQ_TICK, 3'd7, 16'hFFFF, 16'hFFFF);   // fund 0: phases stay put
    send_item(REQ_TRIG, 3'd2, 16'h1234, 16'h4321);
    send_item(REQ_TICK, 3'd0, 16'h0000, 16'h0000);
    wait_idle();

    // harmonic ratios at the top of both registers
    set_config(31'h7FFF_FFFF, 16'hFFFF, 1'b0);
    for (int i = 0; i < VOICES; i++)
      send_item(REQ_LOAD, 3'(i), 16'hFFFF >> i, 16'hFFFF - 16'(i));
    repeat (4) send_item(REQ_TICK, 3'd0, 16'h0000, 16'h0000);
    send_item(REQ_TRIG, 3'd0, 16'h0000, 16'h0000);
    repeat (2) send_item(REQ_TICK, 3'd3, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // zero spacing in membrane mode: every partial runs at the fundamental
    set_config(31'h0123_4567, 16'h0000, 1'b1);
    send_item(REQ_LOAD, 3'd3, 16'h0001, 16'h8000);   // gone after one tick
    repeat (3) send_item(REQ_TICK, 3'd0, 16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    int         sent;
    int         pick;
    logic [1:0] req;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0:       set_config(31'h7FFF_FFFF, 16'hFFFF, 1'b1);
        1:       set_config(rand_fund(), 16'h0000, 1'b0);
        2:       set_config(rand_fund(), 16'($urandom), 1'b1);
        3:       set_config(rand_fund(), 16'h8000, 1'b0);
        4:       set_config(31'($urandom), 16'($urandom), 1'b1);
        default: set_config(rand_fund(), 16'($urandom), 1'($urandom));
      endcase
      quiet = (p == 2);
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // typical voice: load some partials, maybe retrigger, run a few ticks
          repeat ($urandom_range(8, 1)) begin
            send_item(REQ_LOAD, 3'($urandom), rand_weight(), rand_decay());
            sent++;
          end
          if ($urandom_range(1)) begin
            send_item(REQ_TRIG, 3'($urandom), 16'($urandom), 16'($urandom));
            sent++;
          end
          repeat ($urandom_range(12, 1)) begin
            send_item(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
            sent++;
          end
        end else if (pick < 88) begin
          req = 2'($urandom_range(2));
          send_item(req, 3'($urandom), 16'($urandom), 16'($urandom));
          sent++;
        end else begin
          // noise: ignored by the block, not counted
          send_item(REQ_NONE, 3'($urandom), 16'($urandom), 16'($urandom));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Sink stalls for a long time while ticks keep coming, so the output
  // register fills, the sequencer parks at its last step and in_ready drops.
  task automatic test_backpressure();
    wait_idle();
    set_config(31'h0123_4567, 16'h4000, 1'b1);
    for (int i = 0; i < VOICES; i++)
      send_item(REQ_LOAD, 3'(i), 16'hFFFF - 16'(i * 1000), 16'hFFF0);
    hold_request = 1'b1;
    repeat (30) send_item(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    reset_model();
    fill_sine_quarter();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== decaying_partial_additive_oscillator.f =====
+incdir+src
src/dpao_pkg.sv
src/dpao_mul.sv
src/dpao_div.sv
src/dpao_ctrl.sv
src/decaying_partial_additive_oscillator.sv
src/dpao_chk.sv
tb/decaying_partial_additive_oscillator_test.sv
